// ----- src/nal_slice_start_indexer_top_macros.svh -----
// ----------------------------------------------------------------------------
// NAL slice start indexer: assertion macros
// Concurrent checks sampled on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef NAL_SLICE_START_INDEXER_TOP_MACROS_SVH
`define NAL_SLICE_START_INDEXER_TOP_MACROS_SVH

// Same-cycle implication.
`define NSSI_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define NSSI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/nssi_pkg.sv -----
// ----------------------------------------------------------------------------
// nssi_pkg
// Shared types and constants of the NAL slice start indexer.
// ----------------------------------------------------------------------------
package nssi_pkg;

  localparam int OffsetBits = 32;
  localparam int KindBits   = 8;

  localparam logic [23:0] StartPattern = 24'h000001;
  localparam logic [3:0]  H264MinNal   = 4'd5;
  localparam logic [3:0]  HevcMinNal   = 4'd6;
  localparam logic [2:0]  CountMax     = 3'd7;
  localparam logic [5:0]  ZeroCountMax = 6'd63;
  localparam logic [KindBits-1:0] TermKind = '1;

  // Parse phase codes
  localparam logic [3:0] PhIdle         = 4'd0;
  localparam logic [3:0] PhH264Hdr      = 4'd1;
  localparam logic [3:0] PhHevcHdr      = 4'd2;
  localparam logic [3:0] PhMbZ          = 4'd3;
  localparam logic [3:0] PhMbS          = 4'd4;
  localparam logic [3:0] PhStZ          = 4'd5;
  localparam logic [3:0] PhStS          = 4'd6;
  localparam logic [3:0] PhHevcFirst    = 4'd7;
  localparam logic [3:0] PhHevcFirstIrap = 4'd8;
  localparam logic [3:0] PhHevcNoOut    = 4'd9;
  localparam logic [3:0] PhPpsZ         = 4'd10;
  localparam logic [3:0] PhPpsS         = 4'd11;
  localparam logic [3:0] PhExtra        = 4'd12;
  localparam logic [3:0] PhDone         = 4'd13;

  // Configuration register indexes
  localparam int ApbAddrBits = 4;
  localparam logic [1:0] RegCodec     = 2'd0;
  localparam logic [1:0] RegExtra     = 2'd1;
  localparam logic [1:0] RegDepSlices = 2'd2;

  // Result queue
  localparam int FifoDepth = 4;
  localparam int PtrBits   = $clog2(FifoDepth);
  localparam int CntBits   = $clog2(FifoDepth + 1);

  typedef struct packed {
    logic [3:0]          phase;
    logic [5:0]          zc;
    logic [31:0]         gv;
    logic                arm;
    logic [KindBits-1:0] kind;
  } nssi_parse_t;

  typedef struct packed {
    logic                  is_terminator;
    logic [KindBits-1:0]   slice_kind;
    logic [OffsetBits-1:0] byte_offset;
    logic                  last_of_run;
  } nssi_entry_t;

endpackage

// ----- src/nssi_byte_if.sv -----
// ----------------------------------------------------------------------------
// nssi_byte_if
// Input channel: one stream byte per item with its end-of-stream mark.
// ----------------------------------------------------------------------------
interface nssi_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  logic       end_of_stream;

  modport source (output valid, output stream_byte, output end_of_stream, input ready);
  modport sink   (input valid, input stream_byte, input end_of_stream, output ready);
endinterface

// ----- src/nssi_entry_if.sv -----
// ----------------------------------------------------------------------------
// nssi_entry_if
// Output channel: one index entry per item.
// ----------------------------------------------------------------------------
interface nssi_entry_if
  import nssi_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic                  is_terminator;
  logic [KindBits-1:0]   slice_kind;
  logic [OffsetBits-1:0] byte_offset;
  logic                  last_of_run;

  modport source (output valid, output is_terminator, output slice_kind,
                  output byte_offset, output last_of_run, input ready);
  modport sink   (input valid, input is_terminator, input slice_kind,
                  input byte_offset, input last_of_run, output ready);
endinterface

// ----- src/nssi_bit_parser.sv -----
// ----------------------------------------------------------------------------
// nssi_bit_parser
// Walks the eight bits of one byte, MSB first, through the NAL header and
// slice header parser with Exp-Golomb decoding.
// ----------------------------------------------------------------------------
module nssi_bit_parser
  import nssi_pkg::*;
(
  input  nssi_parse_t ps_i,
  input  logic [7:0]  byte_i,
  input  logic        dep_on_i,
  input  logic [2:0]  extra_i,
  output nssi_parse_t ps_o
);

  // Finish a ue(v) field whose suffix phase is sph, with decoded value v.
  function automatic nssi_parse_t ue_done(nssi_parse_t s, logic [3:0] sph,
                                          logic [31:0] v, logic dep,
                                          logic [2:0] extra);
    nssi_parse_t n;
    n = s;
    n.gv = v;
    case (sph)
      PhMbS: begin
        if (v == '0) begin
          n.zc    = '0;
          n.gv    = '0;
          n.phase = PhStZ;
        end else begin
          n.phase = PhDone;
        end
      end
      PhStS: begin
        n.kind  = (v > 32'd255) ? TermKind : v[KindBits-1:0];
        n.arm   = 1'b1;
        n.phase = PhDone;
      end
      PhPpsS: begin
        n.zc = '0;
        n.gv = '0;
        if (dep) begin
          n.phase = PhDone;
        end else if (extra != 3'd0) begin
          n.zc    = {3'b000, extra};
          n.phase = PhExtra;
        end else begin
          n.phase = PhStZ;
        end
      end
      default: n.phase = PhDone;
    endcase
    return n;
  endfunction

  function automatic nssi_parse_t step_bit(nssi_parse_t s, logic b, logic dep,
                                           logic [2:0] extra);
    nssi_parse_t n;
    logic [31:0] gv_sh;
    logic [31:0] gv_sat;
    logic [5:0]  zc_dec;
    logic [5:0]  t6;
    logic [4:0]  t5;
    n      = s;
    gv_sh  = {s.gv[30:0], b};
    gv_sat = s.gv[31] ? '1 : gv_sh;
    zc_dec = (s.zc != 6'd0) ? 6'(s.zc - 6'd1) : 6'd0;
    t6     = gv_sh[14:9];
    t5     = gv_sh[4:0];
    case (s.phase)
      PhH264Hdr: begin
        n.gv = gv_sh;
        n.zc = 6'(s.zc + 6'd1);
        if (s.zc == 6'd7) begin
          n.zc    = '0;
          n.gv    = '0;
          n.phase = (t5 == 5'd1 || t5 == 5'd5) ? PhMbZ : PhDone;
        end
      end
      PhHevcHdr: begin
        n.gv = gv_sh;
        n.zc = 6'(s.zc + 6'd1);
        if (s.zc == 6'd15) begin
          n.zc = '0;
          n.gv = '0;
          if (t6 <= 6'd9) begin
            n.phase = PhHevcFirst;
          end else if (t6 inside {[6'd16:6'd21]}) begin
            n.phase = PhHevcFirstIrap;
          end else begin
            n.phase = PhDone;
          end
        end
      end
      PhMbZ, PhStZ, PhPpsZ: begin
        if (!b) begin
          if (s.zc < ZeroCountMax) n.zc = 6'(s.zc + 6'd1);
        end else if (s.zc != 6'd0) begin
          n.gv    = 32'd1;
          n.phase = 4'(s.phase + 4'd1);
        end else begin
          // code is a single 1 bit: value zero, field done
          n = ue_done(s, 4'(s.phase + 4'd1), '0, dep, extra);
        end
      end
      PhMbS, PhStS, PhPpsS: begin
        n.gv = gv_sat;
        n.zc = zc_dec;
        if (zc_dec == 6'd0) begin
          n = ue_done(n, s.phase, 32'(gv_sat - 32'd1), dep, extra);
        end
      end
      PhHevcFirst: begin
        n.phase = b ? PhPpsZ : PhDone;
        n.zc    = '0;
        n.gv    = '0;
      end
      PhHevcFirstIrap: begin
        n.phase = b ? PhHevcNoOut : PhDone;
      end
      PhHevcNoOut: begin
        n.zc    = '0;
        n.gv    = '0;
        n.phase = PhPpsZ;
      end
      PhExtra: begin
        n.zc = zc_dec;
        if (zc_dec == 6'd0) begin
          n.gv    = '0;
          n.phase = PhStZ;
        end
      end
      default: n = s;
    endcase
    return n;
  endfunction

  nssi_parse_t chain [9];

  always_comb begin
    chain[0] = ps_i;
    for (int i = 0; i < 8; i++) begin
      chain[i+1] = step_bit(chain[i], byte_i[7-i], dep_on_i, extra_i);
    end
  end

  assign ps_o = chain[8];

endmodule

// ----- src/nssi_out_fifo.sv -----
// ----------------------------------------------------------------------------
// nssi_out_fifo
// Small result queue: takes up to two entries per cycle, drives one out.
// ----------------------------------------------------------------------------
module nssi_out_fifo
  import nssi_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [1:0]    push_n_i,
  input  nssi_entry_t   push0_i,
  input  nssi_entry_t   push1_i,
  output logic          space2_o,
  nssi_entry_if.source  entry_o
);
  `include "nal_slice_start_indexer_top_macros.svh"

  nssi_entry_t        mem_q [FifoDepth];
  logic [PtrBits-1:0] wr_q;
  logic [PtrBits-1:0] rd_q;
  logic [CntBits-1:0] cnt_q;
  logic               pop;
  nssi_entry_t        head;

  assign pop      = entry_o.valid && entry_o.ready;
  assign space2_o = cnt_q <= CntBits'(FifoDepth - 2);

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) mem_q[wr_q] <= push0_i;
    if (push_n_i == 2'd2) mem_q[PtrBits'(wr_q + 1'b1)] <= push1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= PtrBits'(wr_q + PtrBits'(push_n_i));
      rd_q  <= PtrBits'(rd_q + PtrBits'(pop));
      cnt_q <= CntBits'(cnt_q + CntBits'(push_n_i) - CntBits'(pop));
    end
  end

  assign head                  = mem_q[rd_q];
  assign entry_o.valid         = cnt_q != '0;
  assign entry_o.is_terminator = head.is_terminator;
  assign entry_o.slice_kind    = head.slice_kind;
  assign entry_o.byte_offset   = head.byte_offset;
  assign entry_o.last_of_run   = head.last_of_run;

  `NSSI_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_q <= CntBits'(FifoDepth), "queue count overflow")
  `NSSI_ASSERT_IMPL(a_push_room, push_n_i != 2'd0, cnt_q <= CntBits'(FifoDepth - 2), "push without room")
  `NSSI_ASSERT_NEXT(a_pop_only, pop && push_n_i == 2'd0, cnt_q == CntBits'($past(cnt_q) - 1'b1), "pop miscounted")
  `NSSI_ASSERT_IMPL(a_pair_last, push_n_i == 2'd2, push1_i.last_of_run && !push0_i.last_of_run, "pair last flag wrong")

endmodule

// ----- src/nal_slice_start_indexer_top.sv -----
// Results of a byte are queued as the byte is taken and leave on entry_o in order.
// Throughput: one byte per cycle while ready; parsed bit by bit, combinationally.
// Each byte yields zero to two entries, held in a 4-entry queue and drained one
// per cycle while entry_o.ready is high; byte_i.ready drops below two free slots.
// Reset: rst_ni, asynchronous active low, clears parse state, queue and registers.
// ----------------------------------------------------------------------------
// nal_slice_start_indexer_top
// Finds Annex-B start codes, parses NAL and slice headers and emits picture
// start entries plus an end-of-stream terminator.
// ----------------------------------------------------------------------------
module nal_slice_start_indexer_top
  import nssi_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ApbAddrBits-1:0] paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  nssi_byte_if.sink              byte_i,
  nssi_entry_if.source           entry_o
);
  `include "nal_slice_start_indexer_top_macros.svh"

  localparam logic [OffsetBits-1:0] PosMax = '1;

  // Configuration
  logic       codec_q;
  logic [2:0] extra_q;
  logic       dep_q;
  logic       cfg_wr;
  logic [1:0] cfg_idx;

  // Stream state
  logic [OffsetBits-1:0] pos_q, pos_d;
  logic [23:0]           recent_q, recent_d;
  logic [OffsetBits-1:0] nal_start_q, nal_start_d;
  logic [2:0]            cnt_q, cnt_d;
  logic [3:0]            phase_q, phase_d;
  logic [5:0]            zc_q, zc_d;
  logic [31:0]           gv_q, gv_d;
  logic                  pend_valid_q, pend_valid_d;
  logic [KindBits-1:0]   pend_kind_q, pend_kind_d;
  logic                  stopped_q, stopped_d;

  logic        byte_acc;
  logic [23:0] recent_sh;
  logic [3:0]  bound;
  logic [3:0]  size_sc;
  logic [3:0]  size_eos;
  nssi_parse_t ps_in;
  nssi_parse_t ps_out;
  nssi_entry_t res [2];
  logic [1:0]  n_res;
  logic [1:0]  push_n;
  logic        space2;

  // ---------------------------------------------------------------------------
  // APB registers
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codec_q <= 1'b0;
      extra_q <= '0;
      dep_q   <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        RegCodec:     codec_q <= pwdata[0];
        RegExtra:     extra_q <= pwdata[2:0];
        RegDepSlices: dep_q   <= pwdata[0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      RegCodec:     prdata = {31'b0, codec_q};
      RegExtra:     prdata = {29'b0, extra_q};
      RegDepSlices: prdata = {31'b0, dep_q};
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Byte processing
  // ---------------------------------------------------------------------------
  assign byte_acc  = byte_i.valid && byte_i.ready;
  assign recent_sh = {recent_q[15:0], byte_i.stream_byte};
  assign bound     = codec_q ? HevcMinNal : H264MinNal;
  assign ps_in     = '{phase: phase_q, zc: zc_q, gv: gv_q, arm: 1'b0, kind: '0};

  nssi_bit_parser u_parser (
    .ps_i     (ps_in),
    .byte_i   (byte_i.stream_byte),
    .dep_on_i (dep_q),
    .extra_i  (extra_q),
    .ps_o     (ps_out)
  );

  always_comb begin
    pos_d        = pos_q;
    recent_d     = recent_q;
    nal_start_d  = nal_start_q;
    cnt_d        = cnt_q;
    phase_d      = phase_q;
    zc_d         = zc_q;
    gv_d         = gv_q;
    pend_valid_d = pend_valid_q;
    pend_kind_d  = pend_kind_q;
    stopped_d    = stopped_q;
    res[0]       = '0;
    res[1]       = '0;
    n_res        = 2'd0;
    size_sc      = 4'({1'b0, cnt_q} + 4'd1);
    size_eos     = '0;

    if (byte_acc) begin
      if (pos_q != '0) begin
        recent_d = recent_sh;
        if (recent_sh == StartPattern) begin
          // close the open NAL, then open a new one
          if (phase_q != PhIdle) begin
            if (size_sc < bound) begin
              stopped_d = 1'b1;
            end else if (pend_valid_q && !stopped_q) begin
              res[0] = '{is_terminator: 1'b0, slice_kind: pend_kind_q,
                         byte_offset: nal_start_q, last_of_run: 1'b0};
              n_res  = 2'd1;
            end
          end
          nal_start_d  = OffsetBits'(pos_q - 2'd2);
          cnt_d        = '0;
          zc_d         = '0;
          gv_d         = '0;
          pend_valid_d = 1'b0;
          phase_d      = codec_q ? PhHevcHdr : PhH264Hdr;
        end else if (phase_q != PhIdle) begin
          if (cnt_q < CountMax) cnt_d = 3'(cnt_q + 3'd1);
          phase_d = ps_out.phase;
          zc_d    = ps_out.zc;
          gv_d    = ps_out.gv;
          if (ps_out.arm) begin
            pend_valid_d = 1'b1;
            pend_kind_d  = ps_out.kind;
          end
        end
      end

      if (pos_q != PosMax) pos_d = OffsetBits'(pos_q + 1'b1);

      if (byte_i.end_of_stream) begin
        size_eos = 4'({1'b0, cnt_d} + 4'd3);
        if (phase_d != PhIdle && size_eos >= bound && pend_valid_d && !stopped_d) begin
          res[n_res[0]] = '{is_terminator: 1'b0, slice_kind: pend_kind_d,
                            byte_offset: nal_start_d, last_of_run: 1'b0};
          n_res = 2'(n_res + 2'd1);
        end
        res[n_res[0]] = '{is_terminator: 1'b1, slice_kind: TermKind,
                          byte_offset: pos_d, last_of_run: 1'b0};
        n_res = 2'(n_res + 2'd1);
        // back to reset state for the next stream
        pos_d        = '0;
        recent_d     = '1;
        nal_start_d  = '0;
        cnt_d        = '0;
        phase_d      = PhIdle;
        zc_d         = '0;
        gv_d         = '0;
        pend_valid_d = 1'b0;
        pend_kind_d  = '0;
        stopped_d    = 1'b0;
      end
    end

    if (n_res == 2'd1) res[0].last_of_run = 1'b1;
    if (n_res == 2'd2) res[1].last_of_run = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      recent_q     <= '1;
      nal_start_q  <= '0;
      cnt_q        <= '0;
      phase_q      <= PhIdle;
      zc_q         <= '0;
      gv_q         <= '0;
      pend_valid_q <= 1'b0;
      pend_kind_q  <= '0;
      stopped_q    <= 1'b0;
    end else begin
      pos_q        <= pos_d;
      recent_q     <= recent_d;
      nal_start_q  <= nal_start_d;
      cnt_q        <= cnt_d;
      phase_q      <= phase_d;
      zc_q         <= zc_d;
      gv_q         <= gv_d;
      pend_valid_q <= pend_valid_d;
      pend_kind_q  <= pend_kind_d;
      stopped_q    <= stopped_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result queue
  // ---------------------------------------------------------------------------
  assign push_n       = byte_acc ? n_res : 2'd0;
  assign byte_i.ready = space2;

  nssi_out_fifo u_out_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .push0_i  (res[0]),
    .push1_i  (res[1]),
    .space2_o (space2),
    .entry_o  (entry_o)
  );

  `NSSI_ASSERT_NEXT(a_eos_clears, byte_acc && byte_i.end_of_stream, pos_q == '0 && phase_q == PhIdle && !stopped_q, "state not cleared after end of stream")
  `NSSI_ASSERT_IMPL(a_eos_term, byte_acc && byte_i.end_of_stream, n_res != 2'd0, "end of stream without terminator")
  `NSSI_ASSERT_NEXT(a_stop_sticky, stopped_q && !(byte_acc && byte_i.end_of_stream), stopped_q, "stop flag dropped early")

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb: NAL slice start indexer testbench
// Feeds Annex-B byte streams (short directed streams, then random
// well-formed streams mixed with noise) under several register settings.
// A local tracker predicts every index entry, and each entry taken from the
// output channel is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nssi_pkg::*;

  localparam int ClkPeriod    = 10;
  localparam int CycleLimit   = 200000;
  localparam int HoldCycles   = 60;
  localparam int PhaseBytes   = 240;
  localparam int MaxReported  = 10;
  localparam int SettleCycles = 8;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [ApbAddrBits-1:0] paddr;
  logic [31:0]            pwdata;
  logic [31:0]            prdata;
  logic                   pready;

  nssi_byte_if  byte_if ();
  nssi_entry_if entry_if ();

  nal_slice_start_indexer_top i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .byte_i  (byte_if),
    .entry_o (entry_if)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Register copies
  logic       cfg_codec;
  logic [2:0] cfg_extra;
  logic       cfg_dep;

  // Stream tracker state
  logic [31:0]         scan_pos;
  logic [23:0]         scan_window;
  logic [31:0]         nal_offset;
  logic [2:0]          nal_bytes;
  logic [3:0]          phase;
  logic [5:0]          gz_count;
  logic [31:0]         gz_value;
  logic                entry_armed;
  logic [KindBits-1:0] armed_kind;
  logic                index_stopped;

  nssi_entry_t step_results[$];
  nssi_entry_t entries_due[$];

  logic [7:0] stream_q[$];
  bit         nal_bits[$];

  int          mismatch_cnt = 0;
  int          bytes_sent   = 0;
  int          hold_asked   = 0;
  bit          sender_steady = 0;
  bit          sink_steady   = 0;
  int unsigned cycle_cnt     = 0;

  // --------------------------------------------------------------------------
  // Entry prediction
  // --------------------------------------------------------------------------
  function automatic void clear_tracker();
    scan_pos      = '0;
    scan_window   = 24'hFFFFFF;
    nal_offset    = '0;
    nal_bytes     = '0;
    phase         = PhIdle;
    gz_count      = '0;
    gz_value      = '0;
    entry_armed   = 1'b0;
    armed_kind    = '0;
    index_stopped = 1'b0;
  endfunction

  function automatic void add_result(input logic term, input logic [KindBits-1:0] kind,
                                     input logic [31:0] off);
    nssi_entry_t r;
    r.is_terminator = term;
    r.slice_kind    = kind;
    r.byte_offset   = off;
    r.last_of_run   = 1'b0;
    step_results.push_back(r);
  endfunction

  function automatic void enter_slice_type();
    gz_count = '0;
    gz_value = '0;
    phase    = PhStZ;
  endfunction

  function automatic void after_pps();
    gz_count = '0;
    gz_value = '0;
    if (cfg_dep) begin
      phase = PhDone;
    end else if (cfg_extra != 3'd0) begin
      gz_count = {3'b000, cfg_extra};
      phase    = PhExtra;
    end else begin
      enter_slice_type();
    end
  endfunction

  // Zero prefix: 0 = stay, 1 = go to suffix, 2 = code complete
  function automatic int golomb_zero(input logic b);
    if (!b) begin
      if (gz_count < ZeroCountMax) gz_count = gz_count + 6'd1;
      return 0;
    end
    gz_value = 32'd1;
    if (gz_count == 6'd0) begin
      gz_value = '0;
      return 2;
    end
    return 1;
  endfunction

  function automatic logic golomb_suffix(input logic b);
    if (gz_value >= 32'h8000_0000) gz_value = '1;
    else gz_value = {gz_value[30:0], b};
    if (gz_count > 6'd0) gz_count = gz_count - 6'd1;
    if (gz_count == 6'd0) begin
      gz_value = gz_value - 32'd1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Called with phase already on the suffix state of the finished code
  function automatic void code_done();
    case (phase)
      PhMbS: begin
        if (gz_value == 32'd0) enter_slice_type();
        else phase = PhDone;
      end
      PhStS: begin
        armed_kind  = (gz_value > 32'd255) ? TermKind : gz_value[7:0];
        entry_armed = 1'b1;
        phase       = PhDone;
      end
      default: after_pps();
    endcase
  endfunction

  function automatic void parse_bit(input logic b);
    logic [5:0] t;
    int         r;
    case (phase)
      PhH264Hdr, PhHevcHdr: begin
        gz_value = {gz_value[30:0], b};
        gz_count = gz_count + 6'd1;
        if (phase == PhH264Hdr && gz_count == 6'd8) begin
          t        = {1'b0, gz_value[4:0]};
          gz_count = '0;
          gz_value = '0;
          phase    = (t == 6'd1 || t == 6'd5) ? PhMbZ : PhDone;
        end else if (phase == PhHevcHdr && gz_count == 6'd16) begin
          t        = gz_value[14:9];
          gz_count = '0;
          gz_value = '0;
          if (t <= 6'd9) phase = PhHevcFirst;
          else if (t >= 6'd16 && t <= 6'd21) phase = PhHevcFirstIrap;
          else phase = PhDone;
        end
      end
      PhMbZ, PhStZ, PhPpsZ: begin
        r = golomb_zero(b);
        if (r == 1) begin
          phase = phase + 4'd1;
        end else if (r == 2) begin
          phase = phase + 4'd1;
          code_done();
        end
      end
      PhMbS, PhStS, PhPpsS: begin
        if (golomb_suffix(b)) code_done();
      end
      PhHevcFirst: begin
        phase    = b ? PhPpsZ : PhDone;
        gz_count = '0;
        gz_value = '0;
      end
      PhHevcFirstIrap: phase = b ? PhHevcNoOut : PhDone;
      PhHevcNoOut: begin
        gz_count = '0;
        gz_value = '0;
        phase    = PhPpsZ;
      end
      PhExtra: begin
        if (gz_count > 6'd0) gz_count = gz_count - 6'd1;
        if (gz_count == 6'd0) enter_slice_type();
      end
      default: ;
    endcase
  endfunction

  function automatic void close_nal(input int size);
    logic [3:0] bound;
    bound = cfg_codec ? HevcMinNal : H264MinNal;
    if (size < int'(bound)) index_stopped = 1'b1;
    else if (entry_armed && !index_stopped) add_result(1'b0, armed_kind, nal_offset);
    entry_armed = 1'b0;
  endfunction

  function automatic void predict_entries(input logic [7:0] b, input logic eos);
    logic [31:0] at;
    logic [31:0] total;
    at = scan_pos;
    step_results.delete();
    if (at != 32'd0) begin
      scan_window = {scan_window[15:0], b};
      if (scan_window == StartPattern) begin
        if (phase != PhIdle) close_nal(int'(nal_bytes) + 1);
        nal_offset  = at - 32'd2;
        nal_bytes   = '0;
        gz_count    = '0;
        gz_value    = '0;
        entry_armed = 1'b0;
        phase       = cfg_codec ? PhHevcHdr : PhH264Hdr;
      end else if (phase != PhIdle) begin
        if (nal_bytes < CountMax) nal_bytes = nal_bytes + 3'd1;
        for (int i = 7; i >= 0; i--) parse_bit(b[i]);
      end
    end
    if (scan_pos != '1) scan_pos = scan_pos + 32'd1;
    if (eos) begin
      if (phase != PhIdle) close_nal(int'(nal_bytes) + 3);
      total = (at != '1) ? at + 32'd1 : at;
      add_result(1'b1, TermKind, total);
      clear_tracker();
    end
    if (step_results.size() > 0) step_results[step_results.size() - 1].last_of_run = 1'b1;
    foreach (step_results[i]) entries_due.push_back(step_results[i]);
  endfunction

  // --------------------------------------------------------------------------
  // Result checking and receiver
  // --------------------------------------------------------------------------
  function automatic void note_error(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MaxReported) $display("ERROR at cycle %0d: %s", cycle_cnt, msg);
  endfunction

  function automatic void check_entry();
    nssi_entry_t want;
    string       got_s;
    got_s = $sformatf("term=%0d kind=%0d off=%0d last=%0d", entry_if.is_terminator,
                      entry_if.slice_kind, entry_if.byte_offset, entry_if.last_of_run);
    if (entries_due.size() == 0) begin
      note_error({"unexpected entry ", got_s});
      return;
    end
    want = entries_due.pop_front();
    if (entry_if.is_terminator !== want.is_terminator ||
        entry_if.slice_kind !== want.slice_kind ||
        entry_if.byte_offset !== want.byte_offset ||
        entry_if.last_of_run !== want.last_of_run)
      note_error($sformatf("entry mismatch: exp term=%0d kind=%0d off=%0d last=%0d, got %s",
                           want.is_terminator, want.slice_kind, want.byte_offset,
                           want.last_of_run, got_s));
  endfunction

  initial begin : entry_sink
    int hold_taken;
    int hold_left;
    hold_taken = 0;
    hold_left  = 0;
    entry_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (entry_if.valid && entry_if.ready) check_entry();
      if (hold_taken != hold_asked) begin
        hold_taken++;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        entry_if.ready <= 1'b0;
      end else begin
        entry_if.ready <= sink_steady || ($urandom_range(99) >= 16);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic eos);
    int gap;
    gap = 0;
    if (!sender_steady && $urandom_range(99) < 16) gap = 1;
    if (gap > 0) begin
      byte_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_if.valid         <= 1'b1;
    byte_if.stream_byte   <= b;
    byte_if.end_of_stream <= eos;
    do @(posedge clk_i); while (!byte_if.ready);
    bytes_sent++;
    predict_entries(b, eos);
  endtask

  // Drop valid and wait until every predicted entry has come out
  task automatic settle();
    byte_if.valid <= 1'b0;
    while (entries_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      RegCodec:     cfg_codec = val[0];
      RegExtra:     cfg_extra = val[2:0];
      RegDepSlices: cfg_dep   = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic codec, input logic [2:0] extra, input logic dep);
    settle();
    reg_write(RegCodec, {31'd0, codec});
    reg_write(RegExtra, {29'd0, extra});
    reg_write(RegDepSlices, {31'd0, dep});
  endtask

  // --------------------------------------------------------------------------
  // Stream generation
  // --------------------------------------------------------------------------
  task automatic push_bits(input logic [63:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) nal_bits.push_back(v[i]);
  endtask

  task automatic push_ue(input logic [63:0] v);
    logic [63:0] code;
    logic [63:0] tmp;
    int          len;
    code = v + 64'd1;
    tmp  = code;
    len  = 0;
    while (tmp != 0) begin
      tmp = tmp >> 1;
      len++;
    end
    push_bits(64'd0, len - 1);
    push_bits(code, len);
  endtask

  task automatic push_slice_type();
    int r;
    int zc;
    r = $urandom_range(99);
    if (r < 75) begin
      push_ue(64'($urandom_range(9)));
    end else if (r < 88) begin
      push_ue(64'($urandom_range(300)));
    end else if (r < 96) begin
      push_ue({32'd0, $urandom()});
    end else begin
      // long zero run: overflows the code value, may saturate the zero count
      zc = $urandom_range(33, 80);
      repeat (zc) nal_bits.push_back(1'b0);
      nal_bits.push_back(1'b1);
      repeat ((zc > 63) ? 63 : zc) nal_bits.push_back(1'($urandom_range(1)));
    end
  endtask

  task automatic build_h264_nal();
    int t;
    t = ($urandom_range(9) < 7) ? ($urandom_range(1) ? 5 : 1) : $urandom_range(31);
    push_bits(64'($urandom_range(15) == 0), 1);
    push_bits(64'($urandom_range(3)), 2);
    push_bits(64'(t), 5);
    if ($urandom_range(99) < 3) return;
    push_ue(64'(($urandom_range(3) == 0) ? $urandom_range(1, 100) : 0));
    push_slice_type();
    push_bits(64'($urandom()), $urandom_range(7));
  endtask

  task automatic build_hevc_nal();
    int r;
    int t;
    r = $urandom_range(99);
    t = (r < 45) ? $urandom_range(9) : (r < 80) ? $urandom_range(16, 21) : $urandom_range(63);
    push_bits(64'($urandom_range(15) == 0), 1);
    push_bits(64'(t), 6);
    push_bits(64'(($urandom_range(7) == 0) ? $urandom_range(63) : 0), 6);
    push_bits(64'($urandom_range(1, 7)), 3);
    if ($urandom_range(99) < 3) return;
    push_bits(64'($urandom_range(4) != 0), 1);
    if (t >= 16 && t <= 21) push_bits(64'($urandom_range(1)), 1);
    push_ue(64'(($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(3)));
    push_bits(64'($urandom()),
              ($urandom_range(4) == 0) ? int'($urandom_range(7)) : int'(cfg_extra));
    push_slice_type();
    push_bits(64'($urandom()), $urandom_range(7));
  endtask

  task automatic send_queued();
    foreach (stream_q[i]) send_byte(stream_q[i], i == stream_q.size() - 1);
  endtask

  task automatic send_stream(input logic hevc, input int nal_cnt);
    int n;
    logic [7:0] v;
    stream_q.delete();
    n = $urandom_range(4);
    repeat (n) stream_q.push_back(8'($urandom_range(255)));
    for (int k = 0; k < nal_cnt; k++) begin
      if ($urandom_range(3) == 0) stream_q.push_back(8'h00);
      stream_q.push_back(8'h00);
      stream_q.push_back(8'h00);
      stream_q.push_back(8'h01);
      nal_bits.delete();
      if (hevc) build_hevc_nal();
      else build_h264_nal();
      while (nal_bits.size() % 8 != 0) nal_bits.push_back(1'($urandom_range(1)));
      for (int i = 0; i < nal_bits.size(); i += 8) begin
        for (int j = 0; j < 8; j++) v[7 - j] = nal_bits[i + j];
        stream_q.push_back(v);
      end
      n = $urandom_range(6);
      repeat (n) stream_q.push_back(8'($urandom_range(255)));
    end
    send_queued();
  endtask

  // Zero-heavy random bytes: stray start codes, short and broken NALs
  task automatic send_noise();
    int n;
    int r;
    stream_q.delete();
    n = $urandom_range(4, 30);
    repeat (n) begin
      r = $urandom_range(99);
      stream_q.push_back((r < 30) ? 8'h00 : (r < 40) ? 8'h01 : 8'($urandom_range(255)));
    end
    send_queued();
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // H.264: IDR slice entry, then a header-only NAL whose slice bits run into
  // the next start code; it is too short and stops all later entries.
  task automatic test_directed_h264();
    logic [7:0] seq [14] = '{8'hAA, 8'h00, 8'h00, 8'h01, 8'h65, 8'h88, 8'h00,
                             8'h00, 8'h01, 8'h41, 8'h00, 8'h00, 8'h01, 8'hFF};
    set_config(1'b0, 3'd0, 1'b0);
    foreach (seq[i]) send_byte(seq[i], i == 13);
  endtask

  // HEVC IRAP slice closed by the last byte: entry and terminator together
  task automatic test_directed_hevc();
    logic [7:0] seq [8] = '{8'h5A, 8'h00, 8'h00, 8'h01, 8'h26, 8'h01, 8'hAC, 8'hFF};
    set_config(1'b1, 3'd0, 1'b0);
    foreach (seq[i]) send_byte(seq[i], i == 7);
  endtask

  task automatic test_random_streams();
    int start;
    for (int s = 0; s < 6; s++) begin
      case (s)
        0: set_config(1'b0, 3'($urandom_range(7)), 1'b0);
        1: set_config(1'b1, 3'd0, 1'b0);
        2: set_config(1'b1, 3'd7, 1'b0);
        3: set_config(1'b1, 3'($urandom_range(7)), 1'b1);
        4: set_config(1'b1, 3'($urandom_range(1, 6)), 1'b0);
        default: set_config(1'b0, 3'd7, 1'b1);
      endcase
      sender_steady = (s == 4);
      sink_steady   = (s == 4);
      start = bytes_sent;
      while (bytes_sent - start < PhaseBytes) begin
        if ($urandom_range(4) == 0) send_noise();
        else send_stream(cfg_codec ^ ($urandom_range(19) == 0), $urandom_range(1, 5));
      end
    end
    sender_steady = 0;
    sink_steady   = 0;
  endtask

  // Hold the receiver while one-byte streams pile up terminators
  task automatic test_backpressure();
    set_config(1'b0, 3'd0, 1'b0);
    hold_asked++;
    repeat (40) send_byte(8'($urandom_range(255)), 1'b1);
    settle();
    send_stream(1'b0, 3);
  endtask

  initial begin
    clear_tracker();
    cfg_codec = 1'b0;
    cfg_extra = 3'd0;
    cfg_dep   = 1'b0;
    rst_ni                <= 1'b0;
    psel                  <= 1'b0;
    penable               <= 1'b0;
    pwrite                <= 1'b0;
    paddr                 <= '0;
    pwdata                <= '0;
    byte_if.valid         <= 1'b0;
    byte_if.stream_byte   <= 8'h00;
    byte_if.end_of_stream <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_h264();
    test_directed_hevc();
    test_random_streams();
    test_backpressure();
    settle();
    if (mismatch_cnt == 0 && entries_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- nal_slice_start_indexer_top.f -----
+incdir+src
src/nssi_pkg.sv
src/nssi_byte_if.sv
src/nssi_entry_if.sv
src/nssi_bit_parser.sv
src/nssi_out_fifo.sv
src/nal_slice_start_indexer_top.sv
bench/tb.sv
